// ===== hw/rtl/mmc_pkg.sv =====
// package: state encoding and field widths for the mean curvature row block
`timescale 1ns / 1ps

package mmc_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned MASS_W  = 31;
  localparam int unsigned ACC_W   = 64;
  localparam int unsigned DVS_W   = MASS_W + 3;
  localparam int unsigned IN_W    = 256;
  localparam int unsigned OUT_W   = 168;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_DIV,
    S_SQ,
    S_SQRT,
    S_DOT,
    S_FIN
  } state_t;

endpackage

// ===== hw/rtl/mesh_mean_curvature_row.sv =====
// top level: streamed laplacian row to mean curvature normal, one shared multiplier
`timescale 1ns / 1ps

// Each input transaction carries one nonzero weight of a vertex's Laplacian row plus
// the neighbor's coordinates; s_tlast marks the last nonzero, which also brings the
// vertex mass and unit normal. The block emits one output transaction per row:
// H = -(sum w*p)/(6*mass) rounded half away from zero and saturated, |H| rounded to
// nearest, |H| signed by -(n . H), and a status code (0 ok, 1 saturated, 2 zero mass).
// Everything runs through a single 33x33 multiplier, a 1-bit-per-cycle divider and
// a 2-bit-per-cycle square root under a small sequencer. A nonzero is accepted and
// then multiplied and accumulated into each of the three sums in turn. A row end adds
// a division for each of the three components, squaring, a square root and a dot
// product, then posts the result; a zero-mass row end goes straight to posting. The
// result sits in an output register, so the next row can start while it waits to be
// taken.
module mesh_mean_curvature_row (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // weight, px, py, pz, mass, unit_nx, unit_ny, unit_nz, zero pad
  input  logic [mmc_pkg::IN_W-1:0]  s_tdata,
  // row_end
  input  logic                      s_tlast,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // hx, hy, hz, magnitude, signed_curvature, status, zero pad
  output logic [mmc_pkg::OUT_W-1:0] m_tdata
);

  mmc_pkg::state_t state, state_next;

  // latched input item
  logic signed [31:0] w;
  logic signed [31:0] p   [3];
  logic signed [31:0] nrm [3];
  logic [30:0]        mass;
  logic               last;

  // accumulators and row status
  logic signed [63:0] sum [3];
  logic               ovf;
  logic               sat;
  logic               zm;

  // sequencer counters
  logic [1:0] idx;
  logic       ph;
  logic [6:0] cnt;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;

  // divider
  logic [33:0] dvs;
  logic [63:0] div_n;
  logic [33:0] div_r;
  logic [34:0] div_t;

  // square root
  logic [63:0] sq;
  logic [63:0] rt_r;
  logic [63:0] rt_b;

  // results
  logic signed [31:0] h [3];
  logic [30:0]        mg;
  logic signed [65:0] dot;

  logic               m_free;
  logic signed [64:0] acc_sum;
  logic [63:0]        dvd_first;
  logic [31:0]        h_mag;
  logic               last_step;

  assign m_free    = !m_tvalid || m_tready;
  assign last_step = (idx == 2'd2);

  // magnitude of the first accumulator plus half the divisor (3 * mass)
  assign dvd_first = (sum[0][63] ? (64'd0 - 64'(sum[0])) : 64'(sum[0]))
                     + {33'd0, mass} + {32'd0, mass, 1'b0};
  assign acc_sum   = {sum[idx][63], sum[idx]} + {prod[63], prod[63:0]};
  assign div_t     = {div_r, div_n[63]};
  assign h_mag     = h[idx][31] ? (32'd0 - 32'(h[idx])) : 32'(h[idx]);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mmc_pkg::S_IDLE: if (s_tvalid) state_next = mmc_pkg::S_ACC;
      mmc_pkg::S_ACC: begin
        if (ph && last_step) begin
          if (!last)           state_next = mmc_pkg::S_IDLE;
          else if (mass == '0) state_next = mmc_pkg::S_FIN;
          else                 state_next = mmc_pkg::S_DIV;
        end
      end
      mmc_pkg::S_DIV:  if (cnt == 7'd64 && last_step) state_next = mmc_pkg::S_SQ;
      mmc_pkg::S_SQ:   if (ph && last_step) state_next = mmc_pkg::S_SQRT;
      mmc_pkg::S_SQRT: if (rt_b == '0) state_next = mmc_pkg::S_DOT;
      mmc_pkg::S_DOT:  if (ph && last_step) state_next = mmc_pkg::S_FIN;
      mmc_pkg::S_FIN:  if (m_free) state_next = mmc_pkg::S_IDLE;
      default:         state_next = mmc_pkg::S_IDLE;
    endcase
  end

  // multiplier operand selection and handshake
  always_comb begin
    s_tready = (state == mmc_pkg::S_IDLE);
    mul_a    = '0;
    mul_b    = '0;
    unique case (state)
      mmc_pkg::S_ACC: begin
        mul_a = {w[31], w};
        mul_b = {p[idx][31], p[idx]};
      end
      mmc_pkg::S_SQ: begin
        mul_a = {1'b0, h_mag};
        mul_b = {1'b0, h_mag};
      end
      mmc_pkg::S_DOT: begin
        mul_a = {nrm[idx][31], nrm[idx]};
        mul_b = {h[idx][31], h[idx]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= mmc_pkg::S_IDLE;
      m_tvalid <= 1'b0;
      sum[0]   <= '0;
      sum[1]   <= '0;
      sum[2]   <= '0;
      ovf      <= 1'b0;
      idx      <= '0;
      ph       <= 1'b0;
      cnt      <= '0;
    end else begin
      state <= state_next;
      // a new result takes the output register as the old one leaves
      if (state == mmc_pkg::S_FIN && m_free) m_tvalid <= 1'b1;
      else if (m_tready)                      m_tvalid <= 1'b0;
      unique case (state)
        mmc_pkg::S_IDLE: begin
          if (s_tvalid) begin
            w      <= s_tdata[31:0];
            p[0]   <= s_tdata[63:32];
            p[1]   <= s_tdata[95:64];
            p[2]   <= s_tdata[127:96];
            mass   <= s_tdata[158:128];
            nrm[0] <= s_tdata[190:159];
            nrm[1] <= s_tdata[222:191];
            nrm[2] <= s_tdata[254:223];
            last   <= s_tlast;
            idx    <= '0;
            ph     <= 1'b0;
          end
        end
        mmc_pkg::S_ACC: begin
          ph <= !ph;
          if (!ph) begin
            prod <= mul_a * mul_b;
          end else begin
            // saturating 64-bit accumulate
            if (acc_sum[64] != acc_sum[63]) begin
              sum[idx] <= acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
              ovf      <= 1'b1;
            end else begin
              sum[idx] <= acc_sum[63:0];
            end
            idx <= idx + 2'd1;
            if (last_step) begin
              idx   <= '0;
              cnt   <= '0;
              div_r <= '0;
              zm    <= (mass == '0);
              sat   <= ovf || (acc_sum[64] != acc_sum[63]);
              dvs   <= {1'b0, mass, 2'b00} + {2'b00, mass, 1'b0};
              div_n <= dvd_first;
            end
          end
        end
        mmc_pkg::S_DIV: begin
          if (cnt != 7'd64) begin
            // restoring division, one quotient bit per cycle
            if (div_t >= {1'b0, dvs}) begin
              div_r <= 34'(div_t - {1'b0, dvs});
              div_n <= {div_n[62:0], 1'b1};
            end else begin
              div_r <= div_t[33:0];
              div_n <= {div_n[62:0], 1'b0};
            end
            cnt <= cnt + 7'd1;
          end else begin
            if (sum[idx] > 64'sd0) begin
              if (div_n > 64'h8000_0000) begin
                h[idx] <= {1'b1, 31'd0};
                sat    <= 1'b1;
              end else begin
                h[idx] <= 32'(64'd0 - div_n);
              end
            end else begin
              if (div_n > 64'h7FFF_FFFF) begin
                h[idx] <= {1'b0, {31{1'b1}}};
                sat    <= 1'b1;
              end else begin
                h[idx] <= div_n[31:0];
              end
            end
            cnt   <= '0;
            div_r <= '0;
            idx   <= idx + 2'd1;
            if (!last_step) begin
              div_n <= (sum[idx + 2'd1][63] ? (64'd0 - 64'(sum[idx + 2'd1]))
                                             : 64'(sum[idx + 2'd1]))
                       + {31'd0, dvs[33:1]};
            end else begin
              idx <= '0;
              ph  <= 1'b0;
              sq  <= '0;
            end
          end
        end
        mmc_pkg::S_SQ: begin
          ph <= !ph;
          if (!ph) begin
            prod <= mul_a * mul_b;
          end else begin
            sq  <= sq + prod[63:0];
            idx <= idx + 2'd1;
            if (last_step) begin
              idx  <= '0;
              rt_r <= '0;
              rt_b <= 64'd1 << 62;
            end
          end
        end
        mmc_pkg::S_SQRT: begin
          if (rt_b != '0) begin
            if (sq >= rt_r + rt_b) begin
              sq   <= sq - (rt_r + rt_b);
              rt_r <= (rt_r >> 1) + rt_b;
            end else begin
              rt_r <= rt_r >> 1;
            end
            rt_b <= rt_b >> 2;
          end else begin
            // round up when the remainder exceeds the root
            if (((sq > rt_r) ? rt_r + 64'd1 : rt_r) > 64'h7FFF_FFFF) begin
              mg  <= {31{1'b1}};
              sat <= 1'b1;
            end else begin
              mg  <= ((sq > rt_r) ? rt_r[30:0] + 31'd1 : rt_r[30:0]);
            end
            dot <= '0;
            idx <= '0;
            ph  <= 1'b0;
          end
        end
        mmc_pkg::S_DOT: begin
          ph <= !ph;
          if (!ph) begin
            prod <= mul_a * mul_b;
          end else begin
            dot <= dot + prod;
            idx <= idx + 2'd1;
            if (last_step) idx <= '0;
          end
        end
        mmc_pkg::S_FIN: begin
          if (m_free) begin
            if (zm) begin
              m_tdata <= {7'd0, mmc_pkg::ST_ZERO, 159'd0};
            end else begin
              m_tdata <= {7'd0, (sat ? mmc_pkg::ST_SAT : mmc_pkg::ST_OK),
                           (dot > 66'sd0) ? (32'd0 - {1'b0, mg}) : {1'b0, mg},
                           mg, h[2], h[1], h[0]};
            end
            sum[0] <= '0;
            sum[1] <= '0;
            sum[2] <= '0;
            ovf    <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // divider remainder always stays below the divisor
  assert property (@(posedge clk) disable iff (rst)
    (state == mmc_pkg::S_DIV) |-> (div_r < dvs))
    else $error("divider remainder out of range");

  // a posted result clears the row accumulators
  assert property (@(posedge clk) disable iff (rst)
    (state == mmc_pkg::S_FIN && m_free) |=>
      (sum[0] == 64'sd0 && sum[1] == 64'sd0 && sum[2] == 64'sd0 && !ovf && m_tvalid))
    else $error("row state not cleared on result");

  // no input is taken while a row is in flight
  assert property (@(posedge clk) disable iff (rst)
    (state != mmc_pkg::S_IDLE) |-> !s_tready)
    else $error("input accepted during row processing");

endmodule
